FILE: src/grid_max_score_path_count_defines.svh
// assertion macros for the grid max score path counter checks
`ifndef GRID_MAX_SCORE_PATH_COUNT_DEFINES_SVH
`define GRID_MAX_SCORE_PATH_COUNT_DEFINES_SVH

// same-cycle implication, off during reset
`define GMSP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gmsp check failed");

// next-cycle implication, off during reset
`define GMSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gmsp check failed");

// next-cycle implication, active during reset
`define GMSP_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gmsp reset check failed");

`endif

FILE: src/gmsp_pkg.sv
// shared types, constants and the modular add function of the grid max score path counter
package gmsp_pkg;

  localparam int VALUE_W = 4;
  localparam int SCORE_W = 13;
  localparam int COUNT_W = 30;
  localparam int CFG_DIM_W = 9;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_SEL_BIT = 2;
  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_DIM_W-1:0] DEF_DIM = 9'd256;
  localparam logic [COUNT_W-1:0] PRIME_MOD = 30'd1000000007;

  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef struct packed {
    logic               reach;
    logic [SCORE_W-1:0] score;
    logic [COUNT_W-1:0] count;
  } cell_state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               first;
    logic               last;
    logic               blk;
    logic               use_above;
    logic               use_diag;
    logic               use_left;
  } cell_ctl_t;

  function automatic logic [COUNT_W-1:0] mod_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, PRIME_MOD}) begin
      sum = sum - {1'b0, PRIME_MOD};
    end
    return sum[COUNT_W-1:0];
  endfunction

endpackage

FILE: src/gmsp_in_if.sv
// cell input channel interface
interface gmsp_in_if;
  logic                        valid;
  logic                        ready;
  logic [gmsp_pkg::VALUE_W-1:0] cell_value;
  logic                        blocked;

  modport source (output valid, output cell_value, output blocked, input ready);
  modport sink (input valid, input cell_value, input blocked, output ready);
endinterface

FILE: src/gmsp_out_if.sv
// result output channel interface
interface gmsp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        reachable;
  logic [gmsp_pkg::SCORE_W-1:0] max_score;
  logic [gmsp_pkg::COUNT_W-1:0] path_count;

  modport source (output valid, output reachable, output max_score, output path_count,
                  input ready);
  modport sink (input valid, input reachable, input max_score, input path_count,
                output ready);
endinterface

FILE: src/grid_max_score_path_count.sv
// Grid max score path counter. Cells of a grid of num_rows by num_cols enter in raster order,
// one per clock at full rate while the queue has room; after the last cell of a grid one word
// gives whether that cell is reachable, the best path score and the number of best paths
// modulo 1000000007. Input keeps flowing while a result waits, until the next last cell
// reaches s2. Throughput is set by the left-neighbor fold in the final stage, which closes
// a loop through left_r, and by the single line buffer of MAX_COLS entries with one read and
// one write each cycle. A four-word queue parts the input side from the scoring pipeline.
// The line buffer needs no clearing after reset. Writing either register restarts the grid at
// the start corner; the user writes registers only while idle; the block does not enforce it.
module grid_max_score_path_count #(
  parameter int MAX_ROWS = gmsp_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gmsp_pkg::DEF_MAX_COLS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  gmsp_in_if.sink                             in_ch,
  gmsp_out_if.source                          out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [gmsp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [gmsp_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [gmsp_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import gmsp_pkg::*;

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int RCMP_W = (CFG_DIM_W > $clog2(MAX_ROWS + 1)) ? CFG_DIM_W : $clog2(MAX_ROWS + 1);
  localparam int CCMP_W = (CFG_DIM_W > $clog2(MAX_COLS + 1)) ? CFG_DIM_W : $clog2(MAX_COLS + 1);
  localparam int Q_W = $bits(cell_ctl_t) + COL_W;

  logic [CFG_DIM_W-1:0] num_rows_r, num_cols_r;
  logic                 cfg_wr;
  logic [RCMP_W-1:0]    rows_raw;
  logic [CCMP_W-1:0]    cols_raw;
  logic [ROW_W-1:0]     rows_m1;
  logic [COL_W-1:0]     cols_m1;

  logic                 q_push, q_pop, q_full, q_valid;
  cell_ctl_t            f_ctl;
  logic [COL_W-1:0]     f_col;
  logic [Q_W-1:0]       q_rd_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[REG_SEL_BIT])
      REG_NUM_ROWS: cfg_prdata = CFG_DATA_W'(num_rows_r);
      default:      cfg_prdata = CFG_DATA_W'(num_cols_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= DEF_DIM;
      num_cols_r <= DEF_DIM;
    end else if (cfg_wr) begin
      case (cfg_paddr[REG_SEL_BIT])
        REG_NUM_ROWS: num_rows_r <= cfg_pwdata[CFG_DIM_W-1:0];
        default:      num_cols_r <= cfg_pwdata[CFG_DIM_W-1:0];
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    rows_raw = RCMP_W'(num_rows_r);
    cols_raw = CCMP_W'(num_cols_r);
    if (rows_raw == '0) begin
      rows_m1 = '0;
    end else if (rows_raw > RCMP_W'(MAX_ROWS)) begin
      rows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1 = ROW_W'(rows_raw - RCMP_W'(1));
    end
    if (cols_raw == '0) begin
      cols_m1 = '0;
    end else if (cols_raw > CCMP_W'(MAX_COLS)) begin
      cols_m1 = COL_W'(MAX_COLS - 1);
    end else begin
      cols_m1 = COL_W'(cols_raw - CCMP_W'(1));
    end
  end

  gmsp_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .ROW_W    (ROW_W),
    .COL_W    (COL_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .rows_m1 (rows_m1),
    .cols_m1 (cols_m1),
    .restart (cfg_wr),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_ctl   (f_ctl),
    .q_col   (f_col)
  );

  gmsp_queue #(
    .W     (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_data   ({f_ctl, f_col}),
    .pop       (q_pop),
    .rd_data   (q_rd_data),
    .full      (q_full),
    .not_empty (q_valid)
  );

  gmsp_back #(
    .MAX_COLS (MAX_COLS),
    .COL_W    (COL_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ctl   (cell_ctl_t'(q_rd_data[Q_W-1:COL_W])),
    .q_col   (q_rd_data[COL_W-1:0]),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );
endmodule

FILE: src/gmsp_queue.sv
// small word queue between the classifying front and the scoring back
module gmsp_queue #(
  parameter int W = 8,
  parameter int DEPTH = gmsp_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         not_empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end
endmodule

FILE: src/gmsp_front.sv
// front end: accepts cells, tracks grid position and classifies each cell
module gmsp_front #(
  parameter int MAX_ROWS = gmsp_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gmsp_pkg::DEF_MAX_COLS,
  parameter int ROW_W = $clog2(MAX_ROWS),
  parameter int COL_W = $clog2(MAX_COLS)
) (
  input  logic                clk,
  input  logic                rst_n,
  gmsp_in_if.sink             in_ch,
  input  logic [ROW_W-1:0]    rows_m1,
  input  logic [COL_W-1:0]    cols_m1,
  input  logic                restart,
  input  logic                q_full,
  output logic                q_push,
  output gmsp_pkg::cell_ctl_t q_ctl,
  output logic [COL_W-1:0]    q_col
);
  import gmsp_pkg::*;

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             first, last_col, last, cols_one;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign q_col       = col_r;

  always_comb begin
    first    = (row_r == '0) && (col_r == '0);
    last_col = (col_r == cols_m1);
    last     = (row_r == rows_m1) && last_col;
    cols_one = (cols_m1 == '0);

    q_ctl.value     = (first || last) ? '0 : in_ch.cell_value;
    q_ctl.blk       = (first || last) ? 1'b0 : in_ch.blocked;
    q_ctl.first     = first;
    q_ctl.last      = last;
    q_ctl.use_above = (row_r != '0) && !cols_one;
    q_ctl.use_diag  = (row_r != '0) && (col_r != '0);
    q_ctl.use_left  = (col_r != '0) || ((row_r != '0) && cols_one);

    row_nxt = row_r;
    col_nxt = col_r;
    if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (q_push) begin
      if (last) begin
        row_nxt = '0;
        col_nxt = '0;
      end else if (last_col) begin
        row_nxt = row_r + ROW_W'(1);
        col_nxt = '0;
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end
endmodule

FILE: src/gmsp_back.sv
// back end: line buffer, neighbor folds and result register
module gmsp_back #(
  parameter int MAX_COLS = gmsp_pkg::DEF_MAX_COLS,
  parameter int COL_W = $clog2(MAX_COLS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  gmsp_pkg::cell_ctl_t q_ctl,
  input  logic [COL_W-1:0]    q_col,
  output logic                q_pop,
  gmsp_out_if.source          out_ch
);
  import gmsp_pkg::*;

  cell_state_t line_mem [MAX_COLS];

  logic               s1_valid_r;
  cell_ctl_t          s1_ctl_r;
  logic [COL_W-1:0]   s1_col_r;
  cell_state_t        rd_data_r;
  cell_state_t        diag_r;

  logic               s2_valid_r;
  cell_ctl_t          s2_ctl_r;
  logic [COL_W-1:0]   s2_col_r;
  logic               ad_any_r, ad_any_nxt;
  logic [SCORE_W-1:0] ad_best_r, ad_best_nxt;
  logic [COUNT_W-1:0] ad_cnt_r, ad_cnt_nxt;

  cell_state_t        left_r;
  logic [COL_W-1:0]   left_col_r;

  logic               out_valid_r, out_valid_nxt;
  cell_state_t        out_r;

  cell_state_t        above;
  cell_state_t        res_nxt;
  logic               adv, retire_last;
  logic               a_ok, d_ok, l_ok, any;
  logic [SCORE_W-1:0] best;
  logic [COUNT_W-1:0] cnt;
  logic [SCORE_W:0]   sum;

  assign retire_last = s2_valid_r && s2_ctl_r.last;
  assign adv         = !(retire_last && out_valid_r && !out_ch.ready);
  assign q_pop       = adv && q_valid;

  // newest write to this column may not be in the read data yet
  assign above = (left_col_r == s1_col_r) ? left_r : rd_data_r;

  // above and diagonal fold
  always_comb begin
    a_ok        = s1_ctl_r.use_above && above.reach;
    d_ok        = s1_ctl_r.use_diag && diag_r.reach;
    ad_any_nxt  = a_ok || d_ok;
    ad_best_nxt = (a_ok && (!d_ok || (above.score >= diag_r.score))) ?
                  above.score : diag_r.score;
    ad_cnt_nxt  = mod_add((a_ok && (above.score == ad_best_nxt)) ? above.count : '0,
                          (d_ok && (diag_r.score == ad_best_nxt)) ? diag_r.count : '0);
  end

  // left fold and cell value
  always_comb begin
    l_ok = s2_ctl_r.use_left && left_r.reach;
    any  = ad_any_r || l_ok;
    best = (ad_any_r && (!l_ok || (ad_best_r >= left_r.score))) ? ad_best_r : left_r.score;
    cnt  = mod_add((ad_any_r && (ad_best_r == best)) ? ad_cnt_r : '0,
                   (l_ok && (left_r.score == best)) ? left_r.count : '0);
    sum  = {1'b0, best} + {{(SCORE_W + 1 - VALUE_W){1'b0}}, s2_ctl_r.value};
    if (s2_ctl_r.first) begin
      res_nxt.reach = 1'b1;
      res_nxt.score = '0;
      res_nxt.count = COUNT_W'(1);
    end else if (s2_ctl_r.blk || !any) begin
      res_nxt = '0;
    end else begin
      res_nxt.reach = 1'b1;
      res_nxt.score = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
      res_nxt.count = cnt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv && retire_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_r <= q_valid;
        s2_valid_r <= s1_valid_r;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r <= q_ctl;
      s1_col_r <= q_col;
      if (s1_valid_r) begin
        diag_r    <= above;
        s2_ctl_r  <= s1_ctl_r;
        s2_col_r  <= s1_col_r;
        ad_any_r  <= ad_any_nxt;
        ad_best_r <= ad_best_nxt;
        ad_cnt_r  <= ad_cnt_nxt;
      end
      if (s2_valid_r) begin
        left_r     <= res_nxt;
        left_col_r <= s2_col_r;
      end
      if (retire_last) begin
        out_r <= res_nxt;
      end
    end
  end

  // line buffer, read before write
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data_r <= line_mem[q_col];
      if (s2_valid_r) begin
        line_mem[s2_col_r] <= res_nxt;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.reachable  = out_r.reach;
  assign out_ch.max_score  = out_r.score;
  assign out_ch.path_count = out_r.count;
endmodule

FILE: src/gmsp_checker.sv
// port-level checks of the grid max score path counter and their bind
`include "grid_max_score_path_count_defines.svh"

module gmsp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_reachable,
  input logic [gmsp_pkg::SCORE_W-1:0] out_max_score,
  input logic [gmsp_pkg::COUNT_W-1:0] out_path_count,
  input logic                         cfg_pready
);
  import gmsp_pkg::*;

  logic zero_payload;

  assign zero_payload = (out_max_score == '0) && (out_path_count == '0);

  `GMSP_ASSERT_IMPL(a_pready_high, 1'b1, cfg_pready)
  `GMSP_ASSERT_RESET(a_reset_no_result, !rst_n, !out_valid)
  `GMSP_ASSERT_IMPL(a_unreached_zero, out_valid && !out_reachable, zero_payload)
  `GMSP_ASSERT_IMPL(a_count_in_range, out_valid, out_path_count < PRIME_MOD)
  `GMSP_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_path_count) && $stable(out_max_score))
endmodule

bind grid_max_score_path_count gmsp_checker u_gmsp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_reachable  (out_ch.reachable),
  .out_max_score  (out_ch.max_score),
  .out_path_count (out_ch.path_count),
  .cfg_pready     (cfg_pready)
);

FILE: verif/grid_max_score_path_count_test.sv
// testbench for the grid max score path counter: raster grid walks checked word by word
module grid_max_score_path_count_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gmsp_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_CELLS = 200;

  typedef enum logic [2:0] {
    FILL_ZERO,
    FILL_NINE,
    FILL_MAX,
    FILL_BLOCKED,
    FILL_BAND,
    FILL_RANDOM
  } grid_fill_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] rows;
    logic [CFG_DIM_W-1:0] cols;
    grid_fill_t           fill;
    logic [15:0]          cut;
    logic                 has_want;
    cell_state_t          want;
  } grid_case_t;

  localparam grid_case_t DIRECTED [14] = '{
    '{9'd1,   9'd1,   FILL_BLOCKED, 16'd0, 1'b1, '{1'b1, 13'd0,    30'd1}},
    '{9'd1,   9'd2,   FILL_BLOCKED, 16'd0, 1'b1, '{1'b1, 13'd0,    30'd1}},
    '{9'd2,   9'd2,   FILL_BLOCKED, 16'd0, 1'b1, '{1'b1, 13'd0,    30'd1}},
    '{9'd1,   9'd3,   FILL_BLOCKED, 16'd0, 1'b1, '{1'b0, 13'd0,    30'd0}},
    '{9'd3,   9'd3,   FILL_BLOCKED, 16'd0, 1'b1, '{1'b0, 13'd0,    30'd0}},
    '{9'd2,   9'd2,   FILL_ZERO,    16'd0, 1'b1, '{1'b1, 13'd0,    30'd3}},
    '{9'd2,   9'd2,   FILL_NINE,    16'd0, 1'b1, '{1'b1, 13'd9,    30'd2}},
    '{9'd1,   9'd3,   FILL_MAX,     16'd0, 1'b1, '{1'b1, 13'd15,   30'd1}},
    '{9'd3,   9'd3,   FILL_ZERO,    16'd0, 1'b1, '{1'b1, 13'd0,    30'd13}},
    '{9'd0,   9'd0,   FILL_NINE,    16'd0, 1'b1, '{1'b1, 13'd0,    30'd1}},
    '{9'd3,   9'd4,   FILL_BAND,    16'd0, 1'b1, '{1'b0, 13'd0,    30'd0}},
    '{9'd4,   9'd4,   FILL_RANDOM,  16'd7, 1'b0, '{1'b0, 13'd0,    30'd0}},
    '{9'd6,   9'd6,   FILL_ZERO,    16'd0, 1'b0, '{1'b0, 13'd0,    30'd0}},
    '{9'd1,   9'd256, FILL_NINE,    16'd0, 1'b1, '{1'b1, 13'd2286, 30'd1}}
  };

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  gmsp_in_if  cell_bus ();
  gmsp_out_if result_bus ();

  grid_max_score_path_count u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (cell_bus),
    .out_ch     (result_bus),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // score model state
  logic [CFG_DIM_W-1:0] rows_cfg = DEF_DIM;
  logic [CFG_DIM_W-1:0] cols_cfg = DEF_DIM;
  cell_state_t          line_buf [DEF_MAX_COLS];
  cell_state_t          left_cell = '0;
  cell_state_t          diag_cell = '0;
  int unsigned          row_i = 0;
  int unsigned          col_i = 0;
  cell_state_t          grid_result_q [$];
  logic                 typed_valid = 1'b0;
  cell_state_t          typed_want = '0;

  int mismatches = 0;
  int words_checked = 0;
  int grids_done = 0;
  int grids_cut = 0;
  int cells_sent = 0;
  int regs_written = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int long_hold = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned clamp_dim(input logic [CFG_DIM_W-1:0] v,
                                            input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  function automatic void restart_walk();
    row_i = 0;
    col_i = 0;
    left_cell = '0;
    diag_cell = '0;
  endfunction

  function automatic void fold_neighbor(inout cell_state_t acc, input cell_state_t nb);
    if (!nb.reach) return;
    if (!acc.reach || nb.score > acc.score) begin
      acc = nb;
    end else if (nb.score == acc.score) begin
      acc.count = COUNT_W'((64'(acc.count) + 64'(nb.count)) % 64'(PRIME_MOD));
    end
  endfunction

  task automatic advance_grid(input logic [VALUE_W-1:0] v_in, input logic b_in);
    int unsigned        nrows;
    int unsigned        ncols;
    bit                 first;
    bit                 last_col;
    bit                 last;
    logic [VALUE_W-1:0] v;
    logic               b;
    cell_state_t        up;
    cell_state_t        acc;
    cell_state_t        nxt;
    logic [SCORE_W:0]   sum;
    nrows = clamp_dim(rows_cfg, DEF_MAX_ROWS);
    ncols = clamp_dim(cols_cfg, DEF_MAX_COLS);
    first = (row_i == 0 && col_i == 0);
    last_col = (col_i + 1 >= ncols);
    last = (row_i + 1 >= nrows) && last_col;
    v = v_in;
    b = b_in;
    up = line_buf[col_i];
    nxt = '0;
    acc = '0;
    if (first || last) begin
      v = '0;
      b = 1'b0;
    end
    if (first) begin
      nxt.reach = 1'b1;
      nxt.count = COUNT_W'(1);
    end else if (!b) begin
      if (row_i > 0) fold_neighbor(acc, up);
      if (col_i > 0) fold_neighbor(acc, left_cell);
      if (row_i > 0 && col_i > 0) fold_neighbor(acc, diag_cell);
      if (acc.reach) begin
        sum = (SCORE_W+1)'(acc.score) + (SCORE_W+1)'(v);
        nxt = acc;
        nxt.score = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
      end
    end
    diag_cell = up;
    line_buf[col_i] = nxt;
    left_cell = nxt;
    if (last) begin
      grid_result_q.push_back(typed_valid ? typed_want : nxt);
      typed_valid = 1'b0;
      grids_done++;
      restart_walk();
    end else if (last_col) begin
      col_i = 0;
      row_i++;
    end else begin
      col_i++;
    end
  endtask

  task automatic push_cell(input logic [VALUE_W-1:0] v, input logic b);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      cell_bus.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    cell_bus.valid = 1'b1;
    cell_bus.cell_value = v;
    cell_bus.blocked = b;
    do @(posedge clk); while (!cell_bus.ready);
    cells_sent++;
    advance_grid(v, b);
    @(negedge clk);
  endtask

  task automatic run_grid(input grid_fill_t fill, input int unsigned cut,
                          input int unsigned value_hi);
    int unsigned        ncols;
    int unsigned        total;
    int unsigned        r;
    logic [VALUE_W-1:0] v;
    logic               b;
    ncols = clamp_dim(cols_cfg, DEF_MAX_COLS);
    total = clamp_dim(rows_cfg, DEF_MAX_ROWS) * ncols;
    if (cut != 0 && cut < total) begin
      total = cut;
      grids_cut++;
    end
    for (int unsigned k = 0; k < total; k++) begin
      r = k / ncols;
      case (fill)
        FILL_ZERO: begin
          v = 4'd0;
          b = 1'b0;
        end
        FILL_NINE: begin
          v = 4'd9;
          b = 1'b0;
        end
        FILL_MAX: begin
          v = 4'd15;
          b = 1'b0;
        end
        FILL_BLOCKED: begin
          v = 4'd15;
          b = 1'b1;
        end
        FILL_BAND: begin
          v = 4'd5;
          b = (r == 1);
        end
        default: begin
          v = ($urandom_range(0, 7) == 0) ? VALUE_W'($urandom_range(0, 15))
                                          : VALUE_W'($urandom_range(0, value_hi));
          b = ($urandom_range(0, 5) == 0);
        end
      endcase
      push_cell(v, b);
    end
  endtask

  task automatic cfg_access(input logic wr, input logic sel,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = wr;
    cfg_paddr = '0;
    cfg_paddr[REG_SEL_BIT] = sel;
    cfg_pwdata = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic check_dim(input logic sel, input logic [CFG_DIM_W-1:0] want);
    logic [CFG_DATA_W-1:0] rd;
    cfg_access(1'b0, sel, '0, rd);
    if (rd !== CFG_DATA_W'(want))
      report_mismatch(sel == REG_NUM_ROWS ? "num_rows readback" : "num_cols readback",
                      64'(rd), 64'(want));
  endtask

  task automatic write_dim(input logic sel, input logic [CFG_DIM_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    cfg_access(1'b1, sel, CFG_DATA_W'(value), rd);
    if (sel == REG_NUM_ROWS) begin
      rows_cfg = value;
    end else begin
      cols_cfg = value;
    end
    restart_walk();
    regs_written++;
    check_dim(sel, value);
  endtask

  task automatic wait_drained;
    cell_bus.valid = 1'b0;
    while (grid_result_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_dims(input logic [CFG_DIM_W-1:0] rows_v,
                          input logic [CFG_DIM_W-1:0] cols_v);
    wait_drained();
    write_dim(REG_NUM_ROWS, rows_v);
    write_dim(REG_NUM_COLS, cols_v);
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        stall = long_hold;
        long_hold = 0;
      end
      if (stall > 0) begin
        result_bus.ready = 1'b0;
        stall--;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        result_bus.ready = 1'b0;
        stall = $urandom_range(1, 15) - 1;
      end else begin
        result_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    cell_state_t want;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (grid_result_q.size() == 0) begin
        report_mismatch("result word with no grid pending", 64'(result_bus.max_score), '0);
      end else begin
        want = grid_result_q.pop_front();
        words_checked++;
        if (result_bus.reachable !== want.reach)
          report_mismatch("reachable", 64'(result_bus.reachable), 64'(want.reach));
        if (result_bus.max_score !== want.score)
          report_mismatch("max_score", 64'(result_bus.max_score), 64'(want.score));
        if (result_bus.path_count !== want.count)
          report_mismatch("path_count", 64'(result_bus.path_count), 64'(want.count));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cell_bus.valid && cell_bus.ready) || (result_bus.valid && result_bus.ready) ||
          cfg_psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("grid_max_score_path_count_test failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned          base;
    int unsigned          hi;
    int unsigned          n;
    logic [CFG_DIM_W-1:0] rows_v;
    logic [CFG_DIM_W-1:0] cols_v;
    rst_n = 1'b0;
    cell_bus.valid = 1'b0;
    cell_bus.cell_value = '0;
    cell_bus.blocked = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    check_dim(REG_NUM_ROWS, DEF_DIM);
    check_dim(REG_NUM_COLS, DEF_DIM);

    src_idle_pct = 20;
    sink_idle_pct = 20;
    for (int i = 0; i < $size(DIRECTED); i++) begin
      set_dims(DIRECTED[i].rows, DIRECTED[i].cols);
      typed_valid = DIRECTED[i].has_want;
      typed_want = DIRECTED[i].want;
      run_grid(DIRECTED[i].fill, 32'(DIRECTED[i].cut), 9);
    end

    // one word per cell while the sink holds off, so the input backs up
    set_dims(9'd1, 9'd1);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    long_hold = HOLD_CYCLES;
    repeat (48) run_grid(FILL_RANDOM, 0, 15);

    base = cells_sent;
    while (cells_sent - base < RANDOM_CELLS) begin
      rows_v = ($urandom_range(0, 15) == 0) ? 9'd0 : CFG_DIM_W'($urandom_range(1, 6));
      cols_v = ($urandom_range(0, 15) == 0) ? 9'd0 : CFG_DIM_W'($urandom_range(1, 8));
      case ($urandom_range(0, 2))
        0: hi = 1;
        1: hi = 9;
        default: hi = 15;
      endcase
      set_dims(rows_v, cols_v);
      src_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
      sink_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
      n = $urandom_range(1, 4);
      repeat (n) run_grid(FILL_RANDOM, 0, hi);
      if ($urandom_range(0, 3) == 0)
        run_grid(FILL_RANDOM, $urandom_range(1, clamp_dim(rows_v, DEF_MAX_ROWS) *
                                                clamp_dim(cols_v, DEF_MAX_COLS)), hi);
    end

    // tall single-column grid at full rate, rows written above range
    src_idle_pct = 0;
    sink_idle_pct = 0;
    set_dims(9'h1FF, 9'd1);
    run_grid(FILL_RANDOM, 0, 9);
    wait_drained();

    $display("walked %0d grids (%0d more cut short) from %0d cells, %0d register writes",
             grids_done, grids_cut, cells_sent, regs_written);
    $display("%0d result words checked, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("grid_max_score_path_count_test passed");
    end else begin
      $display("grid_max_score_path_count_test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/gmsp_pkg.sv
src/gmsp_in_if.sv
src/gmsp_out_if.sv
src/gmsp_queue.sv
src/gmsp_front.sv
src/gmsp_back.sv
src/grid_max_score_path_count.sv
src/gmsp_checker.sv
verif/grid_max_score_path_count_test.sv
